>>> hdl/gsa_pkg.sv
// Shared types, codes and helpers for the generational slot allocator.
`default_nettype none
package gsa_pkg;

  // Request codes
  localparam logic [1:0] REQ_ALLOC    = 2'd0;
  localparam logic [1:0] REQ_VALIDATE = 2'd1;
  localparam logic [1:0] REQ_RELEASE  = 2'd2;

  // Status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [1:0] STATUS_STALE     = 2'd2;

  // Field widths
  localparam int REQ_W       = 2;
  localparam int OWNER_W     = 16;
  localparam int RELATED_W   = 64;
  localparam int KIND_W      = 3;
  localparam int TOKEN_W     = 32;
  localparam int GEN_W       = 29;
  localparam int OUT_INDEX_W = 10;
  localparam int OUT_OCC_W   = 11;
  localparam int COUNT_W     = 32;

  // Packed stream words
  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 232;

  // Kind code 0 marks a free slot; the largest code is stored for kind 6 and 7
  localparam logic [KIND_W-1:0] KIND_FREE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TOP  = 3'd7;
  localparam logic [GEN_W-1:0]  GEN_FIRST = 29'd1;
  localparam logic [GEN_W-1:0]  GEN_LAST  = {GEN_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  // Slot payload held in the slot memory beside the free-list link
  typedef struct packed {
    logic [OWNER_W-1:0]   owner;
    logic [RELATED_W-1:0] related;
    logic [GEN_W-1:0]     gen;
    logic [KIND_W-1:0]    kind;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Per-request events for the statistics block
  typedef struct packed {
    logic done;
    logic alloc_ok;
    logic release_ok;
    logic exhaust;
    logic stale;
    logic wrap;
  } stats_evt_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage
`default_nettype wire

>>> hdl/gsa_slot_mem.sv
// Slot memory: one write port, one registered read port.
`default_nettype none
module gsa_slot_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 123
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> hdl/gsa_stats.sv
// Occupancy, peak occupancy and saturating event counters.
`default_nettype none
module gsa_stats #(
  parameter int SLOTS = 1024,
  parameter int OCC_W = 11
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire gsa_pkg::stats_evt_t         evt,
  output logic [OCC_W-1:0]                 occupancy,
  output logic [OCC_W-1:0]                 peak,
  output logic [gsa_pkg::COUNT_W-1:0]      exhaust_count,
  output logic [gsa_pkg::COUNT_W-1:0]      stale_count,
  output logic [gsa_pkg::COUNT_W-1:0]      wrap_count
);

  logic [OCC_W-1:0] occ_up;

  assign occ_up = occupancy + 1'b1;

  // counters move once per finished request
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy     <= '0;
      peak          <= '0;
      exhaust_count <= '0;
      stale_count   <= '0;
      wrap_count    <= '0;
    end else if (evt.done) begin
      if (evt.alloc_ok) begin
        occupancy <= occ_up;
        if (occ_up > peak) begin
          peak <= occ_up;
        end
      end
      if (evt.release_ok && (occupancy != '0)) begin
        occupancy <= occupancy - 1'b1;
      end
      if (evt.exhaust) begin
        exhaust_count <= gsa_pkg::sat_inc(exhaust_count);
      end
      if (evt.stale) begin
        stale_count <= gsa_pkg::sat_inc(stale_count);
      end
      if (evt.wrap) begin
        wrap_count <= gsa_pkg::sat_inc(wrap_count);
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/generational_slot_allocator_unit.sv
// Top level: generational slot table with free list, request sequencer and result register.
//
//  channel | dir | handshake         | word
//  s       | in  | s_tvalid/s_tready | request (s_tdata)
//  m       | out | m_tvalid/m_tready | result (m_tdata)
//
// Each request runs through IDLE, where the slot memory read issues at accept,
// then EXEC: check, write back and free-list update. The registered memory read
// and the free-head dependency keep a new request out until EXEC completes.
// Reset clears state, free head and fill mark; slots not yet reached by the free
// list read as their reset contents through the fill mark, so no clearing pass runs.
// A request is accepted while the previous result waits; it then holds in EXEC
// until the result register frees.
`default_nettype none
module generational_slot_allocator_unit #(
  parameter int SLOTS = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // req_type[1:0], owner_id[17:2], related_value[81:18], slot_kind[84:82],
  // token_index[116:85], token_generation[148:117], zero pad[151:149]
  input  wire logic [151:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // status[1:0], out_index[11:2], out_generation[40:12], out_related[104:41],
  // out_kind[107:105], occupied[118:108], peak_occupied[129:119],
  // exhaustion_total[161:130], stale_total[193:162], wrap_total[225:194],
  // zero pad[231:226]
  output logic [231:0]      m_tdata
);

  localparam int IW    = $clog2(SLOTS);
  localparam int LW    = IW + 1;
  localparam int OCC_W = $clog2(SLOTS + 1);
  localparam int MW    = gsa_pkg::SLOT_W + LW;
  localparam logic [LW-1:0] LINK_NONE = LW'(SLOTS);

  gsa_pkg::state_t state;

  // request fields
  logic [gsa_pkg::REQ_W-1:0]     in_req;
  logic [gsa_pkg::OWNER_W-1:0]   in_owner;
  logic [gsa_pkg::RELATED_W-1:0] in_related;
  logic [gsa_pkg::KIND_W-1:0]    in_kind;
  logic [gsa_pkg::TOKEN_W-1:0]   in_index;
  logic [gsa_pkg::TOKEN_W-1:0]   in_gen;

  // held request
  logic [gsa_pkg::REQ_W-1:0]     req;
  logic [gsa_pkg::OWNER_W-1:0]   owner;
  logic [gsa_pkg::RELATED_W-1:0] related;
  logic [gsa_pkg::KIND_W-1:0]    kind;
  logic [gsa_pkg::TOKEN_W-1:0]   tok_gen;
  logic                          in_range;
  logic [IW-1:0]                 addr;

  // free list and fill mark
  logic [LW-1:0] head;
  logic [LW-1:0] head_next;
  logic [LW-1:0] fill;
  logic [LW-1:0] fill_next;

  // memory ports
  logic          accept;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [MW-1:0] rd_data;
  logic          wr_en;
  logic [MW-1:0] wr_data;

  // slot as seen by the EXEC state
  logic          pristine;
  gsa_pkg::slot_t cur;
  logic [LW-1:0] cur_link;
  gsa_pkg::slot_t new_slot;
  logic [LW-1:0] new_link;
  logic          tok_ok;
  logic [gsa_pkg::GEN_W-1:0] gen_bump;

  logic          exec_go;
  gsa_pkg::stats_evt_t evt;

  // result fields
  logic [1:0]                    res_status;
  logic [IW-1:0]                 res_index;
  logic [gsa_pkg::GEN_W-1:0]     res_gen;
  logic [gsa_pkg::RELATED_W-1:0] res_related;
  logic [gsa_pkg::KIND_W-1:0]    res_kind;

  logic [1:0]                    out_status;
  logic [IW-1:0]                 out_index;
  logic [gsa_pkg::GEN_W-1:0]     out_gen;
  logic [gsa_pkg::RELATED_W-1:0] out_related;
  logic [gsa_pkg::KIND_W-1:0]    out_kind;

  logic [OCC_W-1:0]            occupancy;
  logic [OCC_W-1:0]            peak;
  logic [gsa_pkg::COUNT_W-1:0] exhaust_count;
  logic [gsa_pkg::COUNT_W-1:0] stale_count;
  logic [gsa_pkg::COUNT_W-1:0] wrap_count;

  // unpack the request word
  assign in_req     = s_tdata[1:0];
  assign in_owner   = s_tdata[17:2];
  assign in_related = s_tdata[81:18];
  assign in_kind    = s_tdata[84:82];
  assign in_index   = s_tdata[116:85];
  assign in_gen     = s_tdata[148:117];

  assign s_tready = (state == gsa_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign exec_go  = (state == gsa_pkg::ST_EXEC) && (!m_tvalid || m_tready);

  // read the free head for allocate, the token slot otherwise
  assign rd_en   = accept;
  assign rd_addr = (in_req == gsa_pkg::REQ_ALLOC) ? head[IW-1:0] : in_index[IW-1:0];

  gsa_slot_mem #(
    .DEPTH (SLOTS),
    .AW    (IW),
    .DW    (MW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data (wr_data)
  );

  // slots at or beyond the fill mark still hold reset contents
  assign pristine = ({1'b0, addr} >= fill);

  always_comb begin
    if (pristine) begin
      cur.owner   = '0;
      cur.related = '0;
      cur.gen     = gsa_pkg::GEN_FIRST;
      cur.kind    = gsa_pkg::KIND_FREE;
      cur_link    = {1'b0, addr} + 1'b1;
    end else begin
      cur      = rd_data[MW-1 -: gsa_pkg::SLOT_W];
      cur_link = rd_data[LW-1:0];
    end
  end

  assign tok_ok = in_range && (cur.kind != gsa_pkg::KIND_FREE)
               && (tok_gen[gsa_pkg::TOKEN_W-1:gsa_pkg::GEN_W] == '0)
               && (tok_gen[gsa_pkg::GEN_W-1:0] == cur.gen)
               && (cur.owner == owner);

  assign gen_bump = (cur.gen == gsa_pkg::GEN_LAST) ? gsa_pkg::GEN_FIRST : cur.gen + 1'b1;

  // request execution
  always_comb begin
    wr_en          = 1'b0;
    new_slot       = cur;
    new_link       = cur_link;
    head_next      = head;
    fill_next      = fill;
    evt            = '0;
    evt.done       = exec_go;
    res_status     = gsa_pkg::STATUS_STALE;
    res_index      = '0;
    res_gen        = '0;
    res_related    = '0;
    res_kind       = '0;
    case (req)
      gsa_pkg::REQ_ALLOC: begin
        if (head >= LINK_NONE) begin
          evt.exhaust = 1'b1;
          res_status  = gsa_pkg::STATUS_EXHAUSTED;
        end else begin
          wr_en            = exec_go;
          new_slot.owner   = owner;
          new_slot.related = related;
          new_slot.kind    = (kind == gsa_pkg::KIND_TOP) ? gsa_pkg::KIND_TOP : kind + 1'b1;
          head_next        = cur_link;
          if (pristine) begin
            fill_next = fill + 1'b1;
          end
          evt.alloc_ok = 1'b1;
          res_status   = gsa_pkg::STATUS_OK;
          res_index    = addr;
          res_gen      = cur.gen;
        end
      end
      gsa_pkg::REQ_VALIDATE: begin
        if (tok_ok) begin
          res_status  = gsa_pkg::STATUS_OK;
          res_related = cur.related;
          res_kind    = cur.kind - 1'b1;
        end else begin
          evt.stale = 1'b1;
        end
      end
      gsa_pkg::REQ_RELEASE: begin
        if (tok_ok) begin
          wr_en            = exec_go;
          new_slot.owner   = '0;
          new_slot.related = '0;
          new_slot.gen     = gen_bump;
          new_slot.kind    = gsa_pkg::KIND_FREE;
          new_link         = head;
          head_next        = {1'b0, addr};
          evt.release_ok   = 1'b1;
          evt.wrap         = (cur.gen == gsa_pkg::GEN_LAST);
          res_status       = gsa_pkg::STATUS_OK;
        end else begin
          evt.stale = 1'b1;
        end
      end
      default: begin
        res_status = gsa_pkg::STATUS_STALE;
      end
    endcase
  end

  assign wr_data = {new_slot, new_link};

  // sequencer, free list and fill mark
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gsa_pkg::ST_IDLE;
      head  <= '0;
      fill  <= '0;
    end else begin
      case (state)
        gsa_pkg::ST_IDLE: begin
          if (accept) begin
            state <= gsa_pkg::ST_EXEC;
          end
        end
        gsa_pkg::ST_EXEC: begin
          if (exec_go) begin
            state <= gsa_pkg::ST_IDLE;
            head  <= head_next;
            fill  <= fill_next;
          end
        end
        default: begin
          state <= gsa_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // hold the accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      req      <= in_req;
      owner    <= in_owner;
      related  <= in_related;
      kind     <= in_kind;
      tok_gen  <= in_gen;
      in_range <= (in_index < gsa_pkg::TOKEN_W'(SLOTS));
      addr     <= rd_addr;
    end
  end

  gsa_stats #(
    .SLOTS (SLOTS),
    .OCC_W (OCC_W)
  ) u_stats (
    .clk           (clk),
    .rst           (rst),
    .evt           (evt),
    .occupancy     (occupancy),
    .peak          (peak),
    .exhaust_count (exhaust_count),
    .stale_count   (stale_count),
    .wrap_count    (wrap_count)
  );

  // result register; counters change only when a new result loads
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_status  <= res_status;
      out_index   <= res_index;
      out_gen     <= res_gen;
      out_related <= res_related;
      out_kind    <= res_kind;
    end
  end

  // pack the result word
  assign m_tdata = {
    6'd0,
    wrap_count,
    stale_count,
    exhaust_count,
    gsa_pkg::OUT_OCC_W'(peak),
    gsa_pkg::OUT_OCC_W'(occupancy),
    out_kind,
    out_related,
    out_gen,
    gsa_pkg::OUT_INDEX_W'(out_index),
    out_status
  };

endmodule
`default_nettype wire
